### rtl/core/pmau_pkg.sv
// Package for the paged memory access unit: field widths, default sizes,
// command and state codes and the page table entry layout. No dependencies.
`default_nettype none

package pmau_pkg;

   localparam int VADDR_W     = 10;
   localparam int VADDR_WORDS = 1 << VADDR_W;
   localparam int DATA_W      = 32;
   localparam int PAGE_W      = 7;
   localparam int PHYS_W      = 7;
   localparam int FRAME_W     = 4;
   localparam int FLAGS_W     = 3;
   localparam int AGE_W       = 32;
   localparam int CMD_W       = 3;

   localparam int PAGE_SIZE_DEF  = 8;
   localparam int NUM_PAGES_DEF  = 128;
   localparam int NUM_FRAMES_DEF = 16;

   localparam int FLAG_PRESENT_BIT = 0;
   localparam int FLAG_DIRTY_BIT   = 1;
   localparam int FLAG_USED_BIT    = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_READ        = 3'd0,
      CMD_WRITE       = 3'd1,
      CMD_ENTRY_WRITE = 3'd2,
      CMD_ENTRY_READ  = 3'd3,
      CMD_PHYS_WRITE  = 3'd4,
      CMD_PHYS_READ   = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [AGE_W-1:0]   age;
      logic [FLAGS_W-1:0] flags;
      logic [FRAME_W-1:0] frame;
   } pte_type;

endpackage

`default_nettype wire

### rtl/core/pmau_ram.sv
// Generic single-clock RAM: one write port, one read port with registered data.
// Used for the page table and the word store. No dependencies.
`default_nettype none

module pmau_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/core/paged_memory_access_unit_core.sv
// Top level of the paged memory access unit: page table and word store with
// read-modify-write control. Depends on pmau_pkg and pmau_ram.
//
// Channel  Dir  Handshake               Beat
// req_*    in   req_valid / req_stall   one command with its operand fields
// rsp_*    out  rsp_valid / rsp_stall   one result for every command
//
// A beat holds the core through accept with page table read, then write-back and
// word store access, then result load into the result register; the next beat
// is taken once the core is back in its idle state.
// After reset a clearing pass zeroes every entry of the page table, with
// req_stall high. A beat is accepted while an earlier result waits on
// rsp_stall; it then holds in its last step until the result is taken.
`default_nettype none

module paged_memory_access_unit_core #(
   parameter int PAGE_SIZE  = pmau_pkg::PAGE_SIZE_DEF,
   parameter int NUM_PAGES  = pmau_pkg::NUM_PAGES_DEF,
   parameter int NUM_FRAMES = pmau_pkg::NUM_FRAMES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [pmau_pkg::CMD_W-1:0]          req_cmd,
   input  logic [pmau_pkg::VADDR_W-1:0]        req_virt_addr,
   input  logic signed [pmau_pkg::DATA_W-1:0]  req_write_data,
   input  logic [pmau_pkg::PAGE_W-1:0]         req_entry_page,
   input  logic [pmau_pkg::FRAME_W-1:0]        req_entry_frame,
   input  logic [pmau_pkg::FLAGS_W-1:0]        req_entry_flags,
   input  logic [pmau_pkg::PHYS_W-1:0]         req_phys_index,

   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_fault,
   output logic [pmau_pkg::PAGE_W-1:0]         rsp_fault_page,
   output logic signed [pmau_pkg::DATA_W-1:0]  rsp_read_data,
   output logic [pmau_pkg::PHYS_W-1:0]         rsp_phys_addr,
   output logic [pmau_pkg::FRAME_W-1:0]        rsp_out_frame,
   output logic [pmau_pkg::FLAGS_W-1:0]        rsp_out_flags,
   output logic [pmau_pkg::AGE_W-1:0]          rsp_out_age
);

   localparam int OFFSET_W   = $clog2(PAGE_SIZE);
   localparam int VPN_W      = $clog2((pmau_pkg::VADDR_WORDS - 1) / PAGE_SIZE + 1);
   localparam int PAGE_IDX_W = $clog2(NUM_PAGES);
   localparam int PHYS_WORDS = NUM_FRAMES * PAGE_SIZE;
   localparam int PHYS_IDX_W = $clog2(PHYS_WORDS);
   localparam int DIV_SHIFT  = pmau_pkg::VADDR_W + OFFSET_W;
   localparam int DIV_MUL    = ((1 << DIV_SHIFT) + PAGE_SIZE - 1) / PAGE_SIZE;
   localparam int FOLD_STEPS = (1 << pmau_pkg::FRAME_W) / NUM_FRAMES;
   localparam int PTE_W      = $bits(pmau_pkg::pte_type);

   pmau_pkg::state_type state_ff, state_in;
   logic [PAGE_IDX_W-1:0] clear_count_ff, clear_count_in;
   logic [pmau_pkg::AGE_W-1:0] access_count_ff, access_count_in;

   pmau_pkg::cmd_type                  cmd_ff;
   logic [pmau_pkg::VADDR_W-1:0]       vaddr_ff;
   logic [VPN_W-1:0]                   vpn_ff;
   logic [pmau_pkg::DATA_W-1:0]        wdata_ff;
   logic [pmau_pkg::PAGE_W-1:0]        epage_ff;
   logic [pmau_pkg::FRAME_W-1:0]       eframe_ff;
   logic [pmau_pkg::FLAGS_W-1:0]       eflags_ff;
   logic [pmau_pkg::PHYS_W-1:0]        pidx_ff;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic                               rsp_fault_ff, rsp_fault_in;
   logic [pmau_pkg::PAGE_W-1:0]        rsp_fault_page_ff, rsp_fault_page_in;
   logic [pmau_pkg::DATA_W-1:0]        rsp_read_data_ff, rsp_read_data_in;
   logic [pmau_pkg::PHYS_W-1:0]        rsp_phys_addr_ff, rsp_phys_addr_in;
   logic [pmau_pkg::FRAME_W-1:0]       rsp_out_frame_ff, rsp_out_frame_in;
   logic [pmau_pkg::FLAGS_W-1:0]       rsp_out_flags_ff, rsp_out_flags_in;
   logic [pmau_pkg::AGE_W-1:0]         rsp_out_age_ff, rsp_out_age_in;

   logic                               accept;
   logic                               load_rsp;
   logic [31:0]                        vpn_prod;
   logic [VPN_W-1:0]                   vpn;

   logic                               pt_wr_en, pt_rd_en;
   logic [PAGE_IDX_W-1:0]              pt_wr_addr, pt_rd_addr;
   pmau_pkg::pte_type                  pt_wr_data, pte_rd;
   logic [PTE_W-1:0]                   pt_rd_data;

   logic                               ws_wr_en, ws_rd_en;
   logic [PHYS_IDX_W-1:0]              ws_addr;
   logic [pmau_pkg::DATA_W-1:0]        ws_rd_data;

   logic                               is_access, page_ok, hit, entry_ok, pidx_ok;
   logic [OFFSET_W-1:0]                vofs;
   logic [pmau_pkg::FRAME_W-1:0]       frame_mod;
   logic [PHYS_IDX_W-1:0]              phys;
   logic [pmau_pkg::AGE_W-1:0]         age_next;

   // page number by reciprocal multiply, exact over the whole address range
   assign vpn_prod = 32'(req_virt_addr) * 32'(DIV_MUL);
   assign vpn      = VPN_W'(vpn_prod >> DIV_SHIFT);
   assign accept   = req_valid && !req_stall;

   assign pte_rd    = pt_rd_data;
   assign is_access = (cmd_ff == pmau_pkg::CMD_READ) || (cmd_ff == pmau_pkg::CMD_WRITE);
   assign page_ok   = 32'(vpn_ff) < 32'(NUM_PAGES);
   assign hit       = is_access && page_ok && pte_rd.flags[pmau_pkg::FLAG_PRESENT_BIT];
   assign entry_ok  = 32'(epage_ff) < 32'(NUM_PAGES);
   assign pidx_ok   = 32'(pidx_ff) < 32'(PHYS_WORDS);
   assign vofs      = OFFSET_W'(32'(vaddr_ff) - 32'(vpn_ff) * 32'(PAGE_SIZE));
   assign age_next  = access_count_ff + 32'd1;

   // fold the frame number into the physical store
   always_comb begin
      frame_mod = pte_rd.frame;
      for (int i = 0; i < FOLD_STEPS; i++) begin
         if (32'(frame_mod) >= 32'(NUM_FRAMES)) begin
            frame_mod = frame_mod - pmau_pkg::FRAME_W'(NUM_FRAMES);
         end
      end
   end

   assign phys = PHYS_IDX_W'(32'(frame_mod) * 32'(PAGE_SIZE) + 32'(vofs));

   always_comb begin
      state_in        = state_ff;
      clear_count_in  = clear_count_ff;
      access_count_in = access_count_ff;
      req_stall       = 1'b1;
      pt_rd_en        = 1'b0;
      pt_rd_addr      = (req_cmd <= pmau_pkg::CMD_W'(pmau_pkg::CMD_WRITE)) ?
                        PAGE_IDX_W'(vpn) : PAGE_IDX_W'(req_entry_page);
      pt_wr_en        = 1'b0;
      pt_wr_addr      = PAGE_IDX_W'(vpn_ff);
      pt_wr_data      = pte_rd;
      ws_wr_en        = 1'b0;
      ws_rd_en        = 1'b0;
      ws_addr         = phys;
      load_rsp        = 1'b0;

      unique case (state_ff)
         pmau_pkg::ST_CLEAR: begin
            pt_wr_en       = 1'b1;
            pt_wr_addr     = clear_count_ff;
            pt_wr_data     = '0;
            clear_count_in = clear_count_ff + PAGE_IDX_W'(1);
            if (clear_count_ff == PAGE_IDX_W'(NUM_PAGES - 1)) begin
               state_in = pmau_pkg::ST_IDLE;
            end
         end
         pmau_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            pt_rd_en  = req_valid;
            if (req_valid) begin
               state_in = pmau_pkg::ST_LOOKUP;
            end
         end
         pmau_pkg::ST_LOOKUP: begin
            state_in = pmau_pkg::ST_FINISH;
            unique case (cmd_ff) inside
               pmau_pkg::CMD_READ, pmau_pkg::CMD_WRITE: begin
                  if (hit) begin
                     pt_wr_en   = 1'b1;
                     pt_wr_data.flags[pmau_pkg::FLAG_USED_BIT] = 1'b1;
                     if (cmd_ff == pmau_pkg::CMD_WRITE) begin
                        pt_wr_data.flags[pmau_pkg::FLAG_DIRTY_BIT] = 1'b1;
                     end
                     pt_wr_data.age  = age_next;
                     access_count_in = age_next;
                     ws_wr_en = (cmd_ff == pmau_pkg::CMD_WRITE);
                     ws_rd_en = (cmd_ff == pmau_pkg::CMD_READ);
                  end
               end
               pmau_pkg::CMD_ENTRY_WRITE: begin
                  pt_wr_en         = entry_ok;
                  pt_wr_addr       = PAGE_IDX_W'(epage_ff);
                  pt_wr_data.frame = eframe_ff;
                  pt_wr_data.flags = eflags_ff;
               end
               pmau_pkg::CMD_PHYS_WRITE: begin
                  ws_addr  = PHYS_IDX_W'(pidx_ff);
                  ws_wr_en = pidx_ok;
               end
               pmau_pkg::CMD_PHYS_READ: begin
                  ws_addr  = PHYS_IDX_W'(pidx_ff);
                  ws_rd_en = pidx_ok;
               end
               default: begin
               end
            endcase
         end
         pmau_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load_rsp = 1'b1;
               state_in = pmau_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pmau_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in      = load_rsp || (rsp_valid_ff && rsp_stall);
      rsp_fault_in      = is_access && !hit;
      rsp_fault_page_in = is_access ? pmau_pkg::PAGE_W'(vpn_ff) : '0;
      rsp_read_data_in  = ((cmd_ff == pmau_pkg::CMD_READ) && hit) ||
                          ((cmd_ff == pmau_pkg::CMD_PHYS_READ) && pidx_ok) ? ws_rd_data : '0;
      rsp_phys_addr_in  = hit ? pmau_pkg::PHYS_W'(phys) : '0;
      rsp_out_frame_in  = '0;
      rsp_out_flags_in  = '0;
      rsp_out_age_in    = '0;
      if ((cmd_ff == pmau_pkg::CMD_ENTRY_READ) && entry_ok) begin
         rsp_out_frame_in = pte_rd.frame;
         rsp_out_flags_in = pte_rd.flags;
         rsp_out_age_in   = pte_rd.age;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= pmau_pkg::ST_CLEAR;
         clear_count_ff  <= '0;
         access_count_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         clear_count_ff  <= clear_count_in;
         access_count_ff <= access_count_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff    <= pmau_pkg::cmd_type'(req_cmd);
         vaddr_ff  <= req_virt_addr;
         vpn_ff    <= vpn;
         wdata_ff  <= req_write_data;
         epage_ff  <= req_entry_page;
         eframe_ff <= req_entry_frame;
         eflags_ff <= req_entry_flags;
         pidx_ff   <= req_phys_index;
      end
      if (load_rsp) begin
         rsp_fault_ff      <= rsp_fault_in;
         rsp_fault_page_ff <= rsp_fault_page_in;
         rsp_read_data_ff  <= rsp_read_data_in;
         rsp_phys_addr_ff  <= rsp_phys_addr_in;
         rsp_out_frame_ff  <= rsp_out_frame_in;
         rsp_out_flags_ff  <= rsp_out_flags_in;
         rsp_out_age_ff    <= rsp_out_age_in;
      end
   end

   pmau_ram #(
      .WIDTH (PTE_W),
      .DEPTH (NUM_PAGES)
   ) u_page_table (
      .clock   (clock),
      .wr_en   (pt_wr_en),
      .wr_addr (pt_wr_addr),
      .wr_data (pt_wr_data),
      .rd_en   (pt_rd_en),
      .rd_addr (pt_rd_addr),
      .rd_data (pt_rd_data)
   );

   pmau_ram #(
      .WIDTH (pmau_pkg::DATA_W),
      .DEPTH (PHYS_WORDS)
   ) u_word_store (
      .clock   (clock),
      .wr_en   (ws_wr_en),
      .wr_addr (ws_addr),
      .wr_data (wdata_ff),
      .rd_en   (ws_rd_en),
      .rd_addr (ws_addr),
      .rd_data (ws_rd_data)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_fault      = rsp_fault_ff;
   assign rsp_fault_page = rsp_fault_page_ff;
   assign rsp_read_data  = $signed(rsp_read_data_ff);
   assign rsp_phys_addr  = rsp_phys_addr_ff;
   assign rsp_out_frame  = rsp_out_frame_ff;
   assign rsp_out_flags  = rsp_out_flags_ff;
   assign rsp_out_age    = rsp_out_age_ff;

   a_accept_to_lookup: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff == pmau_pkg::ST_LOOKUP)
      else $error("accepted beat did not enter lookup");

   a_counter_on_hit_only: assert property (@(posedge clock) disable iff (reset)
      (state_ff != pmau_pkg::ST_LOOKUP) || !hit |=> access_count_ff == $past(access_count_ff))
      else $error("access counter moved without a page hit");

   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      load_rsp |-> !(rsp_valid_ff && rsp_stall))
      else $error("result register loaded over a stalled result");

   a_clear_blocks_traffic: assert property (@(posedge clock) disable iff (reset)
      state_ff == pmau_pkg::ST_CLEAR |-> req_stall && !rsp_valid_ff)
      else $error("traffic during page table clearing pass");

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
// Self-checking testbench for paged_memory_access_unit_core: directed table, then random
// fault/refill sequences, physical write/read pairs and single random beats checked
// against a page table and word store predictor. Depends on pmau_pkg and the core RTL.
module tb_top;

   localparam int PAGE_SIZE  = pmau_pkg::PAGE_SIZE_DEF;
   localparam int NUM_PAGES  = pmau_pkg::NUM_PAGES_DEF;
   localparam int NUM_FRAMES = pmau_pkg::NUM_FRAMES_DEF;
   localparam int PHYS_WORDS = NUM_FRAMES * PAGE_SIZE;

   localparam logic [pmau_pkg::CMD_W-1:0] CMD_SPARE_A = 3'd6;
   localparam logic [pmau_pkg::CMD_W-1:0] CMD_SPARE_B = 3'd7;

   localparam int TOTAL_BEATS = 1950;
   localparam int PHASE_BEATS  = 120;
   localparam int SEND_IDLE_PCT [4] = '{0, 69, 0, 9};
   localparam int RECV_STALL_PCT [4] = '{0, 0, 69, 9};

   typedef struct packed {
      logic [pmau_pkg::CMD_W-1:0]   cmd;
      logic [pmau_pkg::VADDR_W-1:0] vaddr;
      logic [pmau_pkg::DATA_W-1:0]  wdata;
      logic [pmau_pkg::PAGE_W-1:0]  epage;
      logic [pmau_pkg::FRAME_W-1:0] eframe;
      logic [pmau_pkg::FLAGS_W-1:0] eflags;
      logic [pmau_pkg::PHYS_W-1:0]  pidx;
   } beat_type;

   typedef struct packed {
      logic                         fault;
      logic [pmau_pkg::PAGE_W-1:0]  fault_page;
      logic [pmau_pkg::DATA_W-1:0]  read_data;
      logic [pmau_pkg::PHYS_W-1:0]  phys_addr;
      logic [pmau_pkg::FRAME_W-1:0] frame;
      logic [pmau_pkg::FLAGS_W-1:0] flags;
      logic [pmau_pkg::AGE_W-1:0]   age;
   } result_type;

   typedef struct packed {
      beat_type   beat;
      logic       typed;
      result_type want;
   } row_type;

   localparam result_type ZERO_RESULT = '0;

   localparam int NUM_DIRECTED = 25;
   localparam row_type DIRECTED_BEATS [NUM_DIRECTED] = '{
      '{'{pmau_pkg::CMD_ENTRY_READ, 10'd0, 32'd0, 7'd0, 4'd0, 3'd0, 7'd0}, 1'b1,
        ZERO_RESULT},
      '{'{pmau_pkg::CMD_READ, 10'd0, 32'd0, 7'd0, 4'd0, 3'd0, 7'd0}, 1'b1,
        '{1'b1, 7'd0, 32'd0, 7'd0, 4'd0, 3'd0, 32'd0}},
      '{'{pmau_pkg::CMD_WRITE, 10'd1023, 32'hffff_ffff, 7'd0, 4'd0, 3'd0, 7'd0}, 1'b1,
        '{1'b1, 7'd127, 32'd0, 7'd0, 4'd0, 3'd0, 32'd0}},
      '{'{CMD_SPARE_A, 10'h3ff, 32'hffff_ffff, 7'h7f, 4'hf, 3'h7, 7'h7f}, 1'b1, ZERO_RESULT},
      '{'{CMD_SPARE_B, 10'h3ff, 32'hffff_ffff, 7'h7f, 4'hf, 3'h7, 7'h7f}, 1'b1, ZERO_RESULT},
      '{'{pmau_pkg::CMD_ENTRY_WRITE, 10'd0, 32'd0, 7'd127, 4'd15, 3'b001, 7'd0}, 1'b1,
        ZERO_RESULT},
      '{'{pmau_pkg::CMD_WRITE, 10'd1023, 32'h7fff_ffff, 7'd0, 4'd0, 3'd0, 7'd0}, 1'b1,
        '{1'b0, 7'd127, 32'd0, 7'd127, 4'd0, 3'd0, 32'd0}},
      '{'{pmau_pkg::CMD_ENTRY_READ, 10'd0, 32'd0, 7'd127, 4'd0, 3'd0, 7'd0}, 1'b1,
        '{1'b0, 7'd0, 32'd0, 7'd0, 4'd15, 3'b111, 32'd1}},
      '{'{pmau_pkg::CMD_READ, 10'd1023, 32'd0, 7'd0, 4'd0, 3'd0, 7'd0}, 1'b1,
        '{1'b0, 7'd127, 32'h7fff_ffff, 7'd127, 4'd0, 3'd0, 32'd0}},
      '{'{pmau_pkg::CMD_PHYS_WRITE, 10'd0, 32'h8000_0000, 7'd0, 4'd0, 3'd0, 7'd0}, 1'b1,
        ZERO_RESULT},
      '{'{pmau_pkg::CMD_PHYS_READ, 10'd0, 32'd0, 7'd0, 4'd0, 3'd0, 7'd0}, 1'b1,
        '{1'b0, 7'd0, 32'h8000_0000, 7'd0, 4'd0, 3'd0, 32'd0}},
      '{'{pmau_pkg::CMD_ENTRY_WRITE, 10'd0, 32'd0, 7'd0, 4'd0, 3'b111, 7'd0}, 1'b1,
        ZERO_RESULT},
      '{'{pmau_pkg::CMD_READ, 10'd0, 32'd0, 7'd0, 4'd0, 3'd0, 7'd0}, 1'b1,
        '{1'b0, 7'd0, 32'h8000_0000, 7'd0, 4'd0, 3'd0, 32'd0}},
      '{'{pmau_pkg::CMD_ENTRY_WRITE, 10'd0, 32'd0, 7'd0, 4'd0, 3'b110, 7'd0}, 1'b1,
        ZERO_RESULT},
      '{'{pmau_pkg::CMD_READ, 10'd7, 32'd0, 7'd0, 4'd0, 3'd0, 7'd0}, 1'b1,
        '{1'b1, 7'd0, 32'd0, 7'd0, 4'd0, 3'd0, 32'd0}},
      '{'{pmau_pkg::CMD_ENTRY_READ, 10'd0, 32'd0, 7'd0, 4'd0, 3'd0, 7'd0}, 1'b1,
        '{1'b0, 7'd0, 32'd0, 7'd0, 4'd0, 3'b110, 32'd3}},
      '{'{pmau_pkg::CMD_PHYS_WRITE, 10'h3ff, 32'hffff_ffff, 7'h7f, 4'hf, 3'h7, 7'd127},
        1'b1, ZERO_RESULT},
      '{'{pmau_pkg::CMD_PHYS_READ, 10'd0, 32'd0, 7'd0, 4'd0, 3'd0, 7'd127}, 1'b1,
        '{1'b0, 7'd0, 32'hffff_ffff, 7'd0, 4'd0, 3'd0, 32'd0}},
      '{'{pmau_pkg::CMD_ENTRY_WRITE, 10'd0, 32'd0, 7'd64, 4'd8, 3'b101, 7'd0}, 1'b1,
        ZERO_RESULT},
      '{'{pmau_pkg::CMD_WRITE, 10'd517, 32'd0, 7'd0, 4'd0, 3'd0, 7'd0}, 1'b1,
        '{1'b0, 7'd64, 32'd0, 7'd69, 4'd0, 3'd0, 32'd0}},
      '{'{pmau_pkg::CMD_READ, 10'd517, 32'd0, 7'd0, 4'd0, 3'd0, 7'd0}, 1'b1,
        '{1'b0, 7'd64, 32'd0, 7'd69, 4'd0, 3'd0, 32'd0}},
      '{'{pmau_pkg::CMD_WRITE, 10'd0, 32'h5555_aaaa, 7'd0, 4'd0, 3'd0, 7'd0}, 1'b0,
        ZERO_RESULT},
      '{'{pmau_pkg::CMD_PHYS_WRITE, 10'h2aa, 32'h0123_4567, 7'h55, 4'ha, 3'h5, 7'd1}, 1'b0,
        ZERO_RESULT},
      '{'{pmau_pkg::CMD_ENTRY_WRITE, 10'd0, 32'd0, 7'd1, 4'd0, 3'b011, 7'd0}, 1'b0,
        ZERO_RESULT},
      '{'{pmau_pkg::CMD_READ, 10'd9, 32'd0, 7'd0, 4'd0, 3'd0, 7'd0}, 1'b0,
        ZERO_RESULT}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [pmau_pkg::CMD_W-1:0] req_cmd = '0;
   logic [pmau_pkg::VADDR_W-1:0] req_virt_addr = '0;
   logic signed [pmau_pkg::DATA_W-1:0] req_write_data = '0;
   logic [pmau_pkg::PAGE_W-1:0] req_entry_page = '0;
   logic [pmau_pkg::FRAME_W-1:0] req_entry_frame = '0;
   logic [pmau_pkg::FLAGS_W-1:0] req_entry_flags = '0;
   logic [pmau_pkg::PHYS_W-1:0] req_phys_index = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_fault;
   logic [pmau_pkg::PAGE_W-1:0] rsp_fault_page;
   logic signed [pmau_pkg::DATA_W-1:0] rsp_read_data;
   logic [pmau_pkg::PHYS_W-1:0] rsp_phys_addr;
   logic [pmau_pkg::FRAME_W-1:0] rsp_out_frame;
   logic [pmau_pkg::FLAGS_W-1:0] rsp_out_flags;
   logic [pmau_pkg::AGE_W-1:0] rsp_out_age;

   logic [pmau_pkg::FRAME_W-1:0] page_frame [NUM_PAGES];
   logic [pmau_pkg::FLAGS_W-1:0] page_flags [NUM_PAGES];
   logic [pmau_pkg::AGE_W-1:0]   page_age [NUM_PAGES];
   logic [pmau_pkg::DATA_W-1:0]  phys_words [PHYS_WORDS];
   bit                           word_written [PHYS_WORDS];
   logic [pmau_pkg::AGE_W-1:0]   access_count;

   result_type awaited_results [$];
   int mismatch_count = 0;
   int results_seen = 0;
   int beats_sent = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   result_type got_result, want_result;

   paged_memory_access_unit_core #(
      .PAGE_SIZE  (PAGE_SIZE),
      .NUM_PAGES  (NUM_PAGES),
      .NUM_FRAMES (NUM_FRAMES)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_virt_addr   (req_virt_addr),
      .req_write_data  (req_write_data),
      .req_entry_page  (req_entry_page),
      .req_entry_frame (req_entry_frame),
      .req_entry_flags (req_entry_flags),
      .req_phys_index  (req_phys_index),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_fault       (rsp_fault),
      .rsp_fault_page  (rsp_fault_page),
      .rsp_read_data   (rsp_read_data),
      .rsp_phys_addr   (rsp_phys_addr),
      .rsp_out_frame   (rsp_out_frame),
      .rsp_out_flags   (rsp_out_flags),
      .rsp_out_age     (rsp_out_age)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic result_type translate_and_access(input beat_type b);
      result_type r;
      int unsigned page, offset, phys;
      r = '0;
      case (b.cmd) inside
         pmau_pkg::CMD_READ, pmau_pkg::CMD_WRITE: begin
            page = b.vaddr / PAGE_SIZE;
            offset = b.vaddr % PAGE_SIZE;
            r.fault_page = pmau_pkg::PAGE_W'(page);
            if (page >= NUM_PAGES || !page_flags[page][pmau_pkg::FLAG_PRESENT_BIT]) begin
               r.fault = 1'b1;
            end else begin
               page_flags[page][pmau_pkg::FLAG_USED_BIT] = 1'b1;
               if (b.cmd == pmau_pkg::CMD_WRITE) page_flags[page][pmau_pkg::FLAG_DIRTY_BIT] = 1'b1;
               access_count = access_count + 32'd1;
               page_age[page] = access_count;
               phys = (page_frame[page] * PAGE_SIZE + offset) % PHYS_WORDS;
               r.phys_addr = pmau_pkg::PHYS_W'(phys);
               if (b.cmd == pmau_pkg::CMD_WRITE) begin
                  phys_words[phys] = b.wdata;
                  word_written[phys] = 1'b1;
               end else begin
                  r.read_data = phys_words[phys];
               end
            end
         end
         pmau_pkg::CMD_ENTRY_WRITE: begin
            if (b.epage < NUM_PAGES) begin
               page_frame[b.epage] = b.eframe;
               page_flags[b.epage] = b.eflags;
            end
         end
         pmau_pkg::CMD_ENTRY_READ: begin
            if (b.epage < NUM_PAGES) begin
               r.frame = page_frame[b.epage];
               r.flags = page_flags[b.epage];
               r.age = page_age[b.epage];
            end
         end
         pmau_pkg::CMD_PHYS_WRITE: begin
            if (b.pidx < PHYS_WORDS) begin
               phys_words[b.pidx] = b.wdata;
               word_written[b.pidx] = 1'b1;
            end
         end
         pmau_pkg::CMD_PHYS_READ: begin
            if (b.pidx < PHYS_WORDS) r.read_data = phys_words[b.pidx];
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic beat_type random_beat();
      beat_type b;
      b.cmd = pmau_pkg::CMD_W'($urandom_range(7));
      b.vaddr = pmau_pkg::VADDR_W'($urandom);
      b.wdata = $urandom;
      b.epage = pmau_pkg::PAGE_W'($urandom);
      b.eframe = pmau_pkg::FRAME_W'($urandom);
      b.eflags = pmau_pkg::FLAGS_W'($urandom);
      b.pidx = pmau_pkg::PHYS_W'($urandom);
      return b;
   endfunction

   task automatic send_beat(input beat_type b, input logic typed, input result_type want);
      int unsigned page, phys;
      result_type predicted;
      // turn a read of a never-written word into the matching write
      page = b.vaddr / PAGE_SIZE;
      if (b.cmd == pmau_pkg::CMD_READ && page < NUM_PAGES &&
          page_flags[page][pmau_pkg::FLAG_PRESENT_BIT]) begin
         phys = (page_frame[page] * PAGE_SIZE + b.vaddr % PAGE_SIZE) % PHYS_WORDS;
         if (!word_written[phys]) b.cmd = pmau_pkg::CMD_WRITE;
      end
      if (b.cmd == pmau_pkg::CMD_PHYS_READ && b.pidx < PHYS_WORDS && !word_written[b.pidx])
         b.cmd = pmau_pkg::CMD_PHYS_WRITE;
      predicted = translate_and_access(b);
      awaited_results.push_back(typed ? want : predicted);
      send_idle_pct = SEND_IDLE_PCT[(beats_sent / PHASE_BEATS) % 4];
      recv_stall_pct = RECV_STALL_PCT[(beats_sent / PHASE_BEATS) % 4];
      beats_sent++;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= b.cmd;
      req_virt_addr <= b.vaddr;
      req_write_data <= b.wdata;
      req_entry_page <= b.epage;
      req_entry_frame <= b.eframe;
      req_entry_flags <= b.eflags;
      req_phys_index <= b.pidx;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic fault_and_refill();
      beat_type access, fill;
      int unsigned page;
      access = random_beat();
      access.cmd = $urandom_range(1) ? pmau_pkg::CMD_WRITE : pmau_pkg::CMD_READ;
      page = access.vaddr / PAGE_SIZE;
      send_beat(access, 1'b0, ZERO_RESULT);
      if (!page_flags[page][pmau_pkg::FLAG_PRESENT_BIT]) begin
         fill = random_beat();
         fill.cmd = pmau_pkg::CMD_ENTRY_WRITE;
         fill.epage = pmau_pkg::PAGE_W'(page);
         fill.eflags[pmau_pkg::FLAG_PRESENT_BIT] = 1'b1;
         send_beat(fill, 1'b0, ZERO_RESULT);
         send_beat(access, 1'b0, ZERO_RESULT);
      end
      if ($urandom_range(1)) begin
         fill = random_beat();
         fill.cmd = pmau_pkg::CMD_ENTRY_READ;
         fill.epage = pmau_pkg::PAGE_W'(page);
         send_beat(fill, 1'b0, ZERO_RESULT);
      end
   endtask

   task automatic report_mismatch(input string what);
      if (mismatch_count < 40) $display("MISMATCH %0s", what);
      mismatch_count++;
   endtask

   task automatic compare_field(input string name, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("result %0d %s: got %h want %h",
                                   results_seen, name, got, want));
   endtask

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      if (!reset && rsp_valid && !rsp_stall) begin
         got_result = '{rsp_fault, rsp_fault_page, rsp_read_data, rsp_phys_addr,
                        rsp_out_frame, rsp_out_flags, rsp_out_age};
         if (awaited_results.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with none awaited", results_seen));
         end else begin
            want_result = awaited_results.pop_front();
            compare_field("fault", 32'(got_result.fault), 32'(want_result.fault));
            compare_field("fault_page", 32'(got_result.fault_page),
                          32'(want_result.fault_page));
            compare_field("read_data", got_result.read_data, want_result.read_data);
            compare_field("phys_addr", 32'(got_result.phys_addr), 32'(want_result.phys_addr));
            compare_field("out_frame", 32'(got_result.frame), 32'(want_result.frame));
            compare_field("out_flags", 32'(got_result.flags), 32'(want_result.flags));
            compare_field("out_age", got_result.age, want_result.age);
         end
         results_seen++;
      end
   end

   initial begin
      for (int i = 0; i < NUM_PAGES; i++) begin
         page_frame[i] = '0;
         page_flags[i] = '0;
         page_age[i] = '0;
      end
      for (int i = 0; i < PHYS_WORDS; i++) begin
         phys_words[i] = '0;
         word_written[i] = 1'b0;
      end
      access_count = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < NUM_DIRECTED; i++)
         send_beat(DIRECTED_BEATS[i].beat, DIRECTED_BEATS[i].typed, DIRECTED_BEATS[i].want);
      while (beats_sent < TOTAL_BEATS) begin
         case ($urandom_range(99)) inside
            [0:44]: fault_and_refill();
            [45:59]: begin
               beat_type pw, pr;
               pw = random_beat();
               pw.cmd = pmau_pkg::CMD_PHYS_WRITE;
               pr = random_beat();
               pr.cmd = pmau_pkg::CMD_PHYS_READ;
               pr.pidx = pw.pidx;
               send_beat(pw, 1'b0, ZERO_RESULT);
               send_beat(pr, 1'b0, ZERO_RESULT);
            end
            default: send_beat(random_beat(), 1'b0, ZERO_RESULT);
         endcase
      end
      req_valid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0)
         $display("paged_memory_access_unit_core verification clean");
      else
         $display("paged_memory_access_unit_core verification failed");
      $finish;
   end

   initial begin
      #(12 * 400000);
      $display("paged_memory_access_unit_core verification failed");
      $finish;
   end

endmodule
